// ----- hw/rtl/i2cee_pkg.sv -----
package i2cee_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 256;
  localparam int MAX_TRANSFER = 256;
  localparam int POS_W = 13;

  localparam logic [7:0] DIR_READ_BIT = 8'h01;
  localparam logic [7:0] DIR_MASK = 8'hFE;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_EVENT = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  device_address;
    logic [12:0] memory_address;
    logic [8:0]  length;
    logic [7:0]  load_index;
    logic [7:0]  data_byte;
    logic        flag_start_sent;
    logic        flag_address_acked;
    logic        flag_tx_empty;
    logic        flag_byte_finished;
    logic        flag_rx_not_empty;
    logic        flag_ack_failure;
  } in_item_t;

  typedef struct packed {
    logic       issue_start;
    logic       issue_stop;
    logic       ack_enable;
    logic       ack_disable;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
  } out_item_t;

endpackage

// ----- hw/rtl/i2cee_if.sv -----
interface i2cee_in_if;
  import i2cee_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cee_out_if;
  import i2cee_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2c_eeprom_master_sequencer.sv -----
// Throughput: one beat per cycle while the skid stage is empty; the step logic
// sits between the input handshake and a result register backed by a one-entry
// skid stage, which holds a result while the output stalls.
// Reset clears phase, counters, target registers and the valid flags of both output stages.
// The data buffer is not cleared; its entries must be written before they are read (the block does not enforce this).
module i2c_eeprom_master_sequencer #(
  parameter int BUFFER_DEPTH = i2cee_pkg::DEFAULT_BUFFER_DEPTH
) (
  input logic clk,
  input logic rst,
  i2cee_in_if.sink item,
  i2cee_out_if.source result
);
  import i2cee_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int LEN_CAP = (BUFFER_DEPTH < MAX_TRANSFER) ? BUFFER_DEPTH : MAX_TRANSFER;
  localparam logic [8:0] LEN_CAP_V = 9'(LEN_CAP);
  localparam logic [POS_W-1:0] DEPTH_V = POS_W'(BUFFER_DEPTH);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RD_START,
    PH_RD_ADDR,
    PH_RD_MHI,
    PH_RD_MLO,
    PH_RD_RESTART,
    PH_RD_MODE,
    PH_RD_RECV,
    PH_WR_START,
    PH_WR_ADDR,
    PH_WR_MHI,
    PH_WR_NEXT,
    PH_WR_LAST
  } phase_t;

  phase_t      phase, phase_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [8:0]  transfer_length, transfer_length_next;
  logic [7:0]  target_device, target_device_next;
  logic [12:0] target_location, target_location_next;

  logic [7:0]  mem [BUFFER_DEPTH];
  logic [7:0]  rd_data;
  logic        fwd;
  logic [7:0]  fwd_data;
  logic [7:0]  buf_byte;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;

  logic          skid_valid;
  out_item_t     skid_data;
  out_item_t     res;

  logic          fire;
  in_item_t      d;
  logic [8:0]    len_eff;
  logic [POS_W-1:0] lidx_w;
  logic [POS_W-1:0] pos_w;
  logic [POS_W-1:0] cnt_next_w;
  logic [9:0]    pos_inc;

  assign item.ready = !skid_valid && !rst;
  assign fire = item.valid && item.ready;
  assign d = item.data;
  assign buf_byte = fwd ? fwd_data : rd_data;

  assign lidx_w = {{(POS_W-8){1'b0}}, d.load_index};
  assign pos_w = {{(POS_W-9){1'b0}}, byte_count};
  assign cnt_next_w = {{(POS_W-9){1'b0}}, byte_count_next};
  assign raddr = cnt_next_w[AW-1:0];
  assign pos_inc = {1'b0, byte_count} + 10'd1;

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    transfer_length_next = transfer_length;
    target_device_next = target_device;
    target_location_next = target_location;
    res = '0;
    we = 1'b0;
    waddr = lidx_w[AW-1:0];
    wdata = d.data_byte;
    len_eff = d.length;
    if (fire) begin
      case (d.operation)
        OP_LOAD: begin
          if (lidx_w < DEPTH_V) begin
            we = 1'b1;
          end
        end
        OP_READ, OP_WRITE: begin
          if (phase == PH_IDLE) begin
            target_device_next = d.device_address;
            target_location_next = d.memory_address;
            byte_count_next = '0;
            res.issue_start = 1'b1;
            if (d.operation == OP_READ) begin
              if (d.length == 9'd0) begin
                len_eff = 9'd1;
              end
              res.ack_enable = 1'b1;
              phase_next = PH_RD_START;
            end else begin
              phase_next = PH_WR_START;
            end
            transfer_length_next = (len_eff > LEN_CAP_V) ? LEN_CAP_V : len_eff;
          end
        end
        OP_EVENT: begin
          case (phase)
            PH_RD_START, PH_WR_START: begin
              if (d.flag_start_sent) begin
                res.send_valid = 1'b1;
                res.send_byte = target_device & DIR_MASK;
                phase_next = (phase == PH_RD_START) ? PH_RD_ADDR : PH_WR_ADDR;
              end
            end
            PH_RD_ADDR: begin
              if (d.flag_address_acked) begin
                res.send_valid = 1'b1;
                res.send_byte = {3'b000, target_location[12:8]};
                phase_next = PH_RD_MHI;
              end
            end
            PH_RD_MHI, PH_WR_MHI: begin
              if (d.flag_tx_empty) begin
                res.send_valid = 1'b1;
                res.send_byte = target_location[7:0];
                phase_next = (phase == PH_RD_MHI) ? PH_RD_MLO : PH_WR_NEXT;
              end
            end
            PH_RD_MLO: begin
              if (d.flag_tx_empty) begin
                res.issue_start = 1'b1;
                phase_next = PH_RD_RESTART;
              end
            end
            PH_RD_RESTART: begin
              if (d.flag_start_sent) begin
                res.send_valid = 1'b1;
                res.send_byte = target_device | DIR_READ_BIT;
                phase_next = PH_RD_MODE;
              end
            end
            PH_RD_MODE: begin
              if (d.flag_address_acked) begin
                phase_next = PH_RD_RECV;
              end
            end
            PH_RD_RECV: begin
              if (d.flag_rx_not_empty) begin
                if (pos_w < DEPTH_V) begin
                  we = 1'b1;
                  waddr = pos_w[AW-1:0];
                end
                res.rx_valid = 1'b1;
                res.rx_index = byte_count[7:0];
                res.rx_byte = d.data_byte;
                byte_count_next = pos_inc[8:0];
                if (pos_inc >= {1'b0, transfer_length}) begin
                  res.ack_disable = 1'b1;
                  res.issue_stop = 1'b1;
                  res.done_res = 1'b1;
                  phase_next = PH_IDLE;
                end
              end
            end
            PH_WR_ADDR: begin
              if (d.flag_ack_failure) begin
                res.issue_start = 1'b1;
                phase_next = PH_WR_START;
              end else if (d.flag_address_acked) begin
                res.send_valid = 1'b1;
                res.send_byte = {3'b000, target_location[12:8]};
                phase_next = PH_WR_MHI;
              end
            end
            PH_WR_NEXT: begin
              if (d.flag_tx_empty) begin
                if (byte_count < transfer_length) begin
                  res.send_valid = 1'b1;
                  res.send_byte = buf_byte;
                  byte_count_next = pos_inc[8:0];
                end else begin
                  phase_next = PH_WR_LAST;
                end
              end
            end
            PH_WR_LAST: begin
              if (d.flag_byte_finished) begin
                res.issue_stop = 1'b1;
                res.done_res = 1'b1;
                phase_next = PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
    fwd <= we && (waddr == raddr);
    fwd_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_count <= '0;
      transfer_length <= '0;
      target_device <= '0;
      target_location <= '0;
      result.valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      transfer_length <= transfer_length_next;
      target_device <= target_device_next;
      target_location <= target_location_next;
      if (result.ready || !result.valid) begin
        result.valid <= skid_valid || fire;
        skid_valid <= 1'b0;
      end else if (fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result.ready || !result.valid) begin
      result.data <= skid_valid ? skid_data : res;
    end else if (fire) begin
      skid_data <= res;
    end
  end

endmodule
